// ===== hw/rtl/fqnp_pkg.sv =====
`timescale 1ns / 1ps

package fqnp_pkg;

  localparam int QUEUE_SLOTS_DEF = 5;
  localparam int SEND_COUNT_DEF  = 3;
  localparam int FIFO_DEPTH_DEF  = 2;

  localparam int DATA_BYTES = 4;
  localparam int CAL_PULSES = 2;
  localparam int MAX_PULSE  = 1100;

  // Nibble position runs from minus the calibration count up to two past the checksum.
  localparam int POS_W  = $clog2(2 * (DATA_BYTES + 2) + 1) + 1;
  localparam int BIDX_W = POS_W - 1;

  localparam logic signed [POS_W-1:0] POS_START = POS_W'(-CAL_PULSES);
  localparam logic [POS_W-1:0] END_POS  = POS_W'(2 * (DATA_BYTES + 1));
  localparam logic [POS_W-1:0] STOP_POS = POS_W'(2 * (DATA_BYTES + 2));

  localparam logic [10:0] MAX_WIDTH = 11'(MAX_PULSE);

  typedef enum logic [1:0] {
    FUNC_PULSE = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_ABORT = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  cmd;
    logic [31:0] data;
    logic [2:0]  len;
    logic [7:0]  csum;
  } op_t;

  typedef struct packed {
    logic [10:0] pulse_width;
    logic        accepted;
    logic [2:0]  match_count;
    logic [2:0]  free_slots;
  } res_t;

  // Width for each coded nibble value, max * (v + 1) / 17, folded into a table.
  function automatic logic [10:0] pulse_lut(input logic [3:0] v);
    logic [10:0] w;
    case (v)
      4'd0:  w = 11'(MAX_PULSE * 1 / 17);
      4'd1:  w = 11'(MAX_PULSE * 2 / 17);
      4'd2:  w = 11'(MAX_PULSE * 3 / 17);
      4'd3:  w = 11'(MAX_PULSE * 4 / 17);
      4'd4:  w = 11'(MAX_PULSE * 5 / 17);
      4'd5:  w = 11'(MAX_PULSE * 6 / 17);
      4'd6:  w = 11'(MAX_PULSE * 7 / 17);
      4'd7:  w = 11'(MAX_PULSE * 8 / 17);
      4'd8:  w = 11'(MAX_PULSE * 9 / 17);
      4'd9:  w = 11'(MAX_PULSE * 10 / 17);
      4'd10: w = 11'(MAX_PULSE * 11 / 17);
      4'd11: w = 11'(MAX_PULSE * 12 / 17);
      4'd12: w = 11'(MAX_PULSE * 13 / 17);
      4'd13: w = 11'(MAX_PULSE * 14 / 17);
      4'd14: w = 11'(MAX_PULSE * 15 / 17);
      4'd15: w = 11'(MAX_PULSE * 16 / 17);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/fqnp_fifo.sv =====
`timescale 1ns / 1ps

module fqnp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/fqnp_front.sv =====
`timescale 1ns / 1ps

module fqnp_front
  import fqnp_pkg::*;
(
  input  logic [1:0]  func,
  input  logic [7:0]  cmd,
  input  logic [31:0] payload,
  input  logic [7:0]  payload_size,
  input  logic [2:0]  cmd_payload_len,
  output op_t         op
);

  logic [2:0]  len;
  logic [7:0]  keep;
  logic [31:0] data;
  logic [7:0]  csum;

  always_comb begin
    len  = (cmd_payload_len > 3'(DATA_BYTES)) ? 3'(DATA_BYTES) : cmd_payload_len;
    keep = (payload_size > 8'(len)) ? 8'(len) : payload_size;
    csum = cmd;
    for (int b = 0; b < 4; b++) begin
      data[8*b +: 8] = (8'(b) < keep) ? payload[8*b +: 8] : 8'h00;
      csum = csum ^ data[8*b +: 8];
    end
    op.func = func_t'(func);
    op.cmd  = cmd;
    op.data = data;
    op.len  = len;
    op.csum = csum;
  end

endmodule

// ===== hw/rtl/fqnp_back.sv =====
`timescale 1ns / 1ps

module fqnp_back
  import fqnp_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int SEND_COUNT  = SEND_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  op_t  op,
  input  logic op_valid,
  input  logic res_ready,
  output logic fire,
  output res_t res
);

  localparam int IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CW = $clog2(QUEUE_SLOTS + 1);
  localparam int TW = CW + 1;
  localparam int SW = $clog2(SEND_COUNT + 1);

  logic [7:0]  slot_cmd_r   [QUEUE_SLOTS];
  logic [31:0] slot_data_r  [QUEUE_SLOTS];
  logic [7:0]  slot_csum_r  [QUEUE_SLOTS];
  logic [2:0]  slot_len_r   [QUEUE_SLOTS];
  logic [SW-1:0] slot_sends_r [QUEUE_SLOTS];

  logic [IW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [POS_W-1:0]  pos_r, pos_nxt;
  logic                     sent_r, sent_nxt;
  logic [3:0]               prev_r, prev_nxt;

  logic [7:0]        hd_cmd, hd_csum, hd_byte;
  logic [31:0]       hd_data, hd_shift;
  logic [2:0]        hd_len;
  logic [SW-1:0]     hd_sends;
  logic [BIDX_W-1:0] bidx;
  logic [4:0]        shamt;
  logic [3:0]        nib, coded;
  logic [POS_W-1:0]  p, tgt;
  logic [TW-1:0]     tail_sum;
  logic [IW-1:0]     tail;
  logic              q_full, do_drop, add_wr, dec_sends;
  logic [10:0]       width;
  logic              ok;
  logic [CW-1:0]     match_cnt;
  logic [TW-1:0]     span;
  logic              hit;

  assign fire = op_valid && res_ready;

  assign hd_cmd   = slot_cmd_r[head_r];
  assign hd_data  = slot_data_r[head_r];
  assign hd_csum  = slot_csum_r[head_r];
  assign hd_len   = slot_len_r[head_r];
  assign hd_sends = slot_sends_r[head_r];
  assign q_full   = (count_r == CW'(QUEUE_SLOTS));

  // Coded nibble at the current position of the head frame.
  always_comb begin
    bidx     = pos_r[POS_W-1:1];
    shamt    = 5'({bidx - BIDX_W'(1), 3'b000});
    hd_shift = hd_data >> shamt;
    if (bidx == '0) begin
      hd_byte = hd_cmd;
    end else if (bidx <= BIDX_W'(DATA_BYTES)) begin
      hd_byte = (bidx > BIDX_W'(4)) ? 8'h00 : hd_shift[7:0];
    end else begin
      hd_byte = hd_csum;
    end
    nib   = pos_r[0] ? hd_byte[7:4] : hd_byte[3:0];
    coded = nib ^ (4'b0001 << pos_r[1:0]);
    tgt   = POS_W'({4'(hd_len) + 4'd1, 1'b0});
  end

  always_comb begin
    tail_sum = TW'(head_r) + TW'(count_r);
    if (tail_sum >= TW'(QUEUE_SLOTS)) begin
      tail_sum = tail_sum - TW'(QUEUE_SLOTS);
    end
    tail = tail_sum[IW-1:0];
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    sent_nxt  = sent_r;
    prev_nxt  = prev_r;
    width     = '0;
    ok        = 1'b0;
    do_drop   = 1'b0;
    add_wr    = 1'b0;
    dec_sends = 1'b0;
    p         = '0;
    if (fire) begin
      unique case (op.func)
        FUNC_PULSE: begin
          if (count_r == '0) begin
            width = MAX_WIDTH;
          end else if (sent_r && !pos_r[POS_W-1] && coded == prev_r) begin
            // A repeated nibble is split off by a zero pulse.
            sent_nxt = 1'b0;
          end else if (pos_r[POS_W-1]) begin
            width   = (pos_r <= POS_START) ? 11'd0 : MAX_WIDTH;
            pos_nxt = pos_r + POS_W'(1);
          end else begin
            width    = pulse_lut(coded);
            sent_nxt = 1'b1;
            prev_nxt = coded;
            p        = pos_r + POS_W'(1);
            if (p == tgt) begin
              p = END_POS;
            end
            if (p >= STOP_POS) begin
              if (hd_sends <= SW'(1)) begin
                do_drop = 1'b1;
              end else begin
                dec_sends = 1'b1;
              end
              p = POS_START;
            end
            pos_nxt = p;
          end
        end
        FUNC_ADD: begin
          if (!q_full) begin
            ok        = 1'b1;
            add_wr    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        FUNC_ABORT: begin
          if (count_r != '0 && hd_cmd == op.cmd) begin
            ok      = 1'b1;
            do_drop = 1'b1;
            pos_nxt = POS_START;
          end
        end
        FUNC_QUERY: begin
        end
        default: begin
        end
      endcase
    end
    if (do_drop) begin
      count_nxt = count_r - CW'(1);
      head_nxt  = (head_r == IW'(QUEUE_SLOTS - 1)) ? '0 : head_r + IW'(1);
    end
  end

  // Frames are counted against the queue as it stands after this word.
  always_comb begin
    match_cnt = '0;
    span      = '0;
    hit       = 1'b0;
    for (int k = 0; k < QUEUE_SLOTS; k++) begin
      if (IW'(k) >= head_nxt) begin
        span = TW'(k) - TW'(head_nxt);
      end else begin
        span = TW'(k) + TW'(QUEUE_SLOTS) - TW'(head_nxt);
      end
      if (add_wr && IW'(k) == tail) begin
        hit = 1'b1;
      end else begin
        hit = (slot_cmd_r[k] == op.cmd);
      end
      if (span < TW'(count_nxt) && hit) begin
        match_cnt = match_cnt + CW'(1);
      end
    end
  end

  always_comb begin
    res.pulse_width = width;
    res.accepted    = ok;
    res.match_count = 3'(match_cnt);
    res.free_slots  = 3'(CW'(QUEUE_SLOTS) - count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      pos_r   <= POS_START;
      sent_r  <= 1'b0;
      prev_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      sent_r  <= sent_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (add_wr) begin
      slot_cmd_r[tail]   <= op.cmd;
      slot_data_r[tail]  <= op.data;
      slot_csum_r[tail]  <= op.csum;
      slot_len_r[tail]   <= op.len;
      slot_sends_r[tail] <= SW'(SEND_COUNT);
    end else if (dec_sends) begin
      slot_sends_r[head_r] <= hd_sends - SW'(1);
    end
  end

endmodule

// ===== hw/rtl/frame_queue_nibble_pulse_encoder.sv =====
`timescale 1ns / 1ps
// A word is registered in the input queue, and its result in the result queue, before it can be popped.
// Throughput: one word per cycle while the result queue has room; the execute unit works combinationally.
// Two short queues part the input side, the execute unit and the result side.
// Reset (synchronous, active low) empties both queues and the frame queue and puts
// the nibble position back to calibration; frame slot storage is not cleared.

module frame_queue_nibble_pulse_encoder
  import fqnp_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int SEND_COUNT  = SEND_COUNT_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_cmd,
  input  logic [31:0] in_payload,
  input  logic [7:0]  in_payload_size,
  input  logic [2:0]  in_cmd_payload_len,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [10:0] out_pulse_width,
  output logic        out_accepted,
  output logic [2:0]  out_match_count,
  output logic [2:0]  out_free_slots
);

  op_t  op_in, op_q;
  res_t res_d, res_q;
  logic op_empty, op_pop;
  logic res_full;
  logic [$bits(op_t)-1:0]  op_bits;
  logic [$bits(res_t)-1:0] res_bits;

  fqnp_front u_front (
    .func            (in_func),
    .cmd             (in_cmd),
    .payload         (in_payload),
    .payload_size    (in_payload_size),
    .cmd_payload_len (in_cmd_payload_len),
    .op              (op_in)
  );

  fqnp_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_op_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (op_in),
    .full  (in_full),
    .pop   (op_pop),
    .rdata (op_bits),
    .empty (op_empty)
  );

  assign op_q = op_t'(op_bits);

  fqnp_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .SEND_COUNT  (SEND_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op_q),
    .op_valid  (!op_empty),
    .res_ready (!res_full),
    .fire      (op_pop),
    .res       (res_d)
  );

  fqnp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_pop),
    .wdata (res_d),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign res_q           = res_t'(res_bits);
  assign out_pulse_width = res_q.pulse_width;
  assign out_accepted    = res_q.accepted;
  assign out_match_count = res_q.match_count;
  assign out_free_slots  = res_q.free_slots;

endmodule

// ===== hw/rtl/fqnp_checker.sv =====
`timescale 1ns / 1ps

module fqnp_checker #(
  parameter int QUEUE_SLOTS = 5
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [10:0] out_pulse_width,
  input logic        out_accepted,
  input logic [2:0]  out_match_count,
  input logic [2:0]  out_free_slots
);

  // Reset leaves no word waiting and room for new ones.
  assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // An add or an abort that went through never carries a pulse.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_accepted |-> out_pulse_width == 11'd0)
    else $error("accepted word carries a pulse width");

  // Matching frames and free slots together never exceed the queue size.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (QUEUE_SLOTS > 7) ||
      (4'(out_match_count) + 4'(out_free_slots) <= 4'(QUEUE_SLOTS)))
    else $error("match count and free slots exceed queue size");

  // A word that is not taken stays in place.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_pulse_width) &&
      $stable(out_accepted) && $stable(out_match_count) && $stable(out_free_slots))
    else $error("stalled result word changed");

endmodule

bind frame_queue_nibble_pulse_encoder fqnp_checker #(
  .QUEUE_SLOTS (QUEUE_SLOTS)
) u_fqnp_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fqnp_pkg::*;

  localparam int SLOTS        = QUEUE_SLOTS_DEF;
  localparam int SENDS        = SEND_COUNT_DEF;
  localparam int RANDOM_WORDS = 1000;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 35;

  // One word for the input side, with an optional hand-computed outcome.
  typedef struct packed {
    func_t       f;
    logic [7:0]  cmd;
    logic [31:0] payload;
    logic [7:0]  size;
    logic [2:0]  len;
    bit          known;
    res_t        want;
  } enc_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_func = FUNC_QUERY;
  logic [7:0]  in_cmd = 8'h00;
  logic [31:0] in_payload = 32'h0;
  logic [7:0]  in_payload_size = 8'h00;
  logic [2:0]  in_cmd_payload_len = 3'd0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [10:0] out_pulse_width;
  logic        out_accepted;
  logic [2:0]  out_match_count;
  logic [2:0]  out_free_slots;

  frame_queue_nibble_pulse_encoder uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_cmd             (in_cmd),
    .in_payload         (in_payload),
    .in_payload_size    (in_payload_size),
    .in_cmd_payload_len (in_cmd_payload_len),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_pulse_width    (out_pulse_width),
    .out_accepted       (out_accepted),
    .out_match_count    (out_match_count),
    .out_free_slots     (out_free_slots)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame queue and encoder state as this testbench sees it.
  logic [7:0]  fr_cmd   [SLOTS];
  logic [31:0] fr_data  [SLOTS];
  logic [7:0]  fr_csum  [SLOTS];
  logic [2:0]  fr_len   [SLOTS];
  int          fr_sends [SLOTS];
  int          q_head = 0;
  int          q_count = 0;
  int          nib_pos = -CAL_PULSES;
  bit          rep_armed = 1'b0;
  logic [3:0]  last_nib = 4'h0;

  res_t pending_results[$];
  res_t mon_want;
  bit   calm = 1'b0;
  int   mismatches = 0;
  int   results_checked = 0;
  int   stall_cycles = 0;
  int   n_pulse = 0, n_add = 0, n_add_ok = 0, n_abort = 0, n_abort_ok = 0, n_query = 0;
  int   frames_sent = 0;

  function automatic logic [3:0] coded_nib(int slot, int pos);
    logic [7:0] b;
    logic [3:0] n;
    int k;
    k = pos / 2;
    if (k == 0) b = fr_cmd[slot];
    else if (k <= DATA_BYTES) b = fr_data[slot][8*(k-1) +: 8];
    else b = fr_csum[slot];
    n = pos[0] ? b[7:4] : b[3:0];
    return n ^ (4'd1 << (pos % 4));
  endfunction

  function automatic void pop_frame();
    q_count--;
    q_head = (q_head + 1) % SLOTS;
  endfunction

  function automatic logic [2:0] queued_matches(logic [7:0] c);
    int n;
    n = 0;
    for (int k = 0; k < q_count; k++) begin
      if (fr_cmd[(q_head + k) % SLOTS] == c) n++;
    end
    return 3'(n);
  endfunction

  function automatic int next_width();
    int h;
    int w;
    logic [3:0] v;
    h = q_head;
    if (q_count == 0) return MAX_PULSE;
    // A nibble equal to the last one sent needs a zero pulse in front of it.
    if (rep_armed && nib_pos >= 0 && coded_nib(h, nib_pos) == last_nib) begin
      rep_armed = 1'b0;
      return 0;
    end
    if (nib_pos < 0) begin
      w = (nib_pos <= -2) ? 0 : MAX_PULSE;
      nib_pos++;
      return w;
    end
    v = coded_nib(h, nib_pos);
    w = MAX_PULSE * (int'(v) + 1) / 17;
    rep_armed = 1'b1;
    last_nib = v;
    nib_pos++;
    // Payload bytes past the command's length are skipped up to the checksum.
    if (nib_pos == 2 * (int'(fr_len[h]) + 1)) nib_pos = 2 * (DATA_BYTES + 1);
    if (nib_pos >= 2 * (DATA_BYTES + 2)) begin
      if (fr_sends[h] <= 1) begin
        pop_frame();
        frames_sent++;
      end else begin
        fr_sends[h]--;
      end
      nib_pos = -CAL_PULSES;
    end
    return w;
  endfunction

  function automatic res_t predict_word(enc_word_t w);
    res_t r;
    int s, len, keep;
    logic [31:0] d;
    r = '0;
    case (w.f)
      FUNC_PULSE: begin
        r.pulse_width = 11'(next_width());
      end
      FUNC_ADD: begin
        if (q_count < SLOTS) begin
          s = (q_head + q_count) % SLOTS;
          len = (int'(w.len) > DATA_BYTES) ? DATA_BYTES : int'(w.len);
          keep = (int'(w.size) > len) ? len : int'(w.size);
          d = (keep >= 4) ? w.payload : (w.payload & ((32'd1 << (8 * keep)) - 32'd1));
          fr_cmd[s] = w.cmd;
          fr_data[s] = d;
          fr_len[s] = 3'(len);
          fr_sends[s] = SENDS;
          fr_csum[s] = w.cmd ^ d[7:0] ^ d[15:8] ^ d[23:16] ^ d[31:24];
          q_count++;
          r.accepted = 1'b1;
        end
      end
      FUNC_ABORT: begin
        if (q_count != 0 && fr_cmd[q_head] == w.cmd) begin
          pop_frame();
          nib_pos = -CAL_PULSES;
          r.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.match_count = queued_matches(w.cmd);
    r.free_slots = 3'(SLOTS - q_count);
    return r;
  endfunction

  function automatic enc_word_t mk_row(func_t f, logic [7:0] c, logic [31:0] p,
                                       logic [7:0] sz, logic [2:0] ln, bit k,
                                       logic [10:0] pw, bit a, logic [2:0] m,
                                       logic [2:0] fs);
    enc_word_t r;
    r.f = f;
    r.cmd = c;
    r.payload = p;
    r.size = sz;
    r.len = ln;
    r.known = k;
    r.want.pulse_width = pw;
    r.want.accepted = a;
    r.want.match_count = m;
    r.want.free_slots = fs;
    return r;
  endfunction

  task automatic send_word(input enc_word_t w);
    res_t pred;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_push <= 1'b1;
    in_func <= w.f;
    in_cmd <= w.cmd;
    in_payload <= w.payload;
    in_payload_size <= w.size;
    in_cmd_payload_len <= w.len;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pred = predict_word(w);
    pending_results.push_back(w.known ? w.want : pred);
    case (w.f)
      FUNC_PULSE: n_pulse++;
      FUNC_ADD: begin
        n_add++;
        if (pred.accepted) n_add_ok++;
      end
      FUNC_ABORT: begin
        n_abort++;
        if (pred.accepted) n_abort_ok++;
      end
      default: n_query++;
    endcase
  endtask

  always @(posedge clk) begin
    out_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result word with nothing expected: width %0d acc %0d match %0d free %0d",
                   $realtime, out_pulse_width, out_accepted, out_match_count, out_free_slots);
        mismatches++;
      end else begin
        mon_want = pending_results.pop_front();
        results_checked++;
        if (out_pulse_width !== mon_want.pulse_width || out_accepted !== mon_want.accepted ||
            out_match_count !== mon_want.match_count ||
            out_free_slots !== mon_want.free_slots) begin
          if (mismatches < 10)
            $display("%0t: mismatch width %0d/%0d acc %0d/%0d match %0d/%0d free %0d/%0d",
                     $realtime, mon_want.pulse_width, out_pulse_width,
                     mon_want.accepted, out_accepted, mon_want.match_count,
                     out_match_count, mon_want.free_slots, out_free_slots);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    enc_word_t dir_rows[$];
    enc_word_t w;
    int i, pick, add_pct;

    for (int k = 0; k < SLOTS; k++) begin
      fr_cmd[k] = 8'h00;
      fr_data[k] = 32'h0;
      fr_csum[k] = 8'h00;
      fr_len[k] = 3'd0;
      fr_sends[k] = 0;
    end

    // Empty queue, then fill it to the brim with extreme payloads.
    dir_rows.push_back(mk_row(FUNC_PULSE, 8'h00, 32'h0, 8'd0, 3'd0, 1, MAX_WIDTH, 0, 3'd0, 3'd5));
    dir_rows.push_back(mk_row(FUNC_QUERY, 8'hFF, 32'hFFFF_FFFF, 8'd255, 3'd7, 1, 11'd0, 0, 3'd0,
                              3'd5));
    dir_rows.push_back(mk_row(FUNC_ABORT, 8'h00, 32'h0, 8'd0, 3'd0, 1, 11'd0, 0, 3'd0, 3'd5));
    dir_rows.push_back(mk_row(FUNC_ADD, 8'h30, 32'hFFFF_FFFF, 8'd255, 3'd7, 1, 11'd0, 1, 3'd1,
                              3'd4));
    dir_rows.push_back(mk_row(FUNC_ADD, 8'h00, 32'h0, 8'd0, 3'd0, 1, 11'd0, 1, 3'd1, 3'd3));
    dir_rows.push_back(mk_row(FUNC_ADD, 8'hFF, 32'h1234_5678, 8'd2, 3'd4, 1, 11'd0, 1, 3'd1,
                              3'd2));
    dir_rows.push_back(mk_row(FUNC_ADD, 8'h3C, 32'hA5A5_A5A5, 8'd4, 3'd3, 1, 11'd0, 1, 3'd1,
                              3'd1));
    dir_rows.push_back(mk_row(FUNC_ADD, 8'hFF, 32'h0, 8'd1, 3'd1, 1, 11'd0, 1, 3'd2, 3'd0));
    // Add to a full queue is refused; counting still works while full.
    dir_rows.push_back(mk_row(FUNC_ADD, 8'h11, 32'h0, 8'd4, 3'd4, 1, 11'd0, 0, 3'd0, 3'd0));
    dir_rows.push_back(mk_row(FUNC_QUERY, 8'hFF, 32'h0, 8'd0, 3'd0, 1, 11'd0, 0, 3'd2, 3'd0));
    // Calibration pair, then data nibbles; 0x30 codes two equal nibbles in a row.
    dir_rows.push_back(mk_row(FUNC_PULSE, 8'h30, 32'h0, 8'd0, 3'd0, 1, 11'd0, 0, 3'd1, 3'd0));
    dir_rows.push_back(mk_row(FUNC_PULSE, 8'h30, 32'h0, 8'd0, 3'd0, 1, MAX_WIDTH, 0, 3'd1, 3'd0));
    repeat (4) dir_rows.push_back(mk_row(FUNC_PULSE, 8'h30, 32'h0, 8'd0, 3'd0, 0, 11'd0, 0, 3'd0,
                                         3'd0));
    // Abort with the wrong command, then the right one, mid-frame.
    dir_rows.push_back(mk_row(FUNC_ABORT, 8'h00, 32'h0, 8'd0, 3'd0, 1, 11'd0, 0, 3'd1, 3'd0));
    dir_rows.push_back(mk_row(FUNC_ABORT, 8'h30, 32'h0, 8'd0, 3'd0, 1, 11'd0, 1, 3'd0, 3'd1));
    dir_rows.push_back(mk_row(FUNC_PULSE, 8'h00, 32'h0, 8'd0, 3'd0, 1, 11'd0, 0, 3'd1, 3'd1));
    repeat (6) dir_rows.push_back(mk_row(FUNC_PULSE, 8'h00, 32'h0, 8'd0, 3'd0, 0, 11'd0, 0, 3'd0,
                                         3'd0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) send_word(dir_rows[k]);

    for (i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 300 && i < 550);
      // Alternate between filling phases and draining phases.
      add_pct = ((i / 100) % 2 == 0) ? 15 : 2;
      pick = $urandom_range(99);
      if (pick < add_pct) w.f = FUNC_ADD;
      else if (pick < add_pct + 10) w.f = FUNC_ABORT;
      else if (pick < add_pct + 18) w.f = FUNC_QUERY;
      else w.f = FUNC_PULSE;
      case ($urandom_range(4))
        0: w.cmd = 8'h00;
        1: w.cmd = 8'h30;
        2: w.cmd = 8'hA5;
        3: w.cmd = 8'hFF;
        default: w.cmd = 8'($urandom);
      endcase
      if (w.f == FUNC_ABORT && q_count > 0 && $urandom_range(99) < 60) w.cmd = fr_cmd[q_head];
      w.payload = $urandom;
      w.size = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
      w.len = 3'($urandom_range(7));
      w.known = 1'b0;
      w.want = '0;
      send_word(w);
    end
    in_push <= 1'b0;
    calm = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words: %0d pulses, %0d adds (%0d taken), %0d aborts (%0d taken)",
             results_checked, n_pulse, n_add, n_add_ok, n_abort, n_abort_ok);
    $display("%0d queries, %0d frames sent to completion, %0d mismatches",
             n_query, frames_sent, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
